// ----- rtl/core/rmdc_pkg.sv -----
// rmdc_pkg: shared widths, reset values, register indexes and control types
// for the running mean / deviation block. No dependencies.
package rmdc_pkg;

  // default parameter values
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  // fixed field widths
  localparam int DATA_W     = 32;
  localparam int DEV_W      = 31;
  localparam int SEEN_W     = 24;
  localparam int VAR_W      = 47;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MEAN_DIV_W = 64;
  localparam int RAD_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int CFG_IDX_W  = 2;

  // reset values of the configuration registers
  localparam logic signed [DATA_W-1:0] TARGET_MEAN_RST = 32'sd0;
  localparam logic [DEV_W-1:0]         TARGET_DEV_RST  = 31'd65536;
  localparam logic [DEV_W-1:0]         TOLERANCE_RST   = 31'd66;

  // saturation limits
  localparam logic [DATA_W-1:0] MEAN_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MEAN_MIN = 32'h8000_0000;
  localparam logic [DEV_W-1:0]  DEV_MAX  = {DEV_W{1'b1}};
  localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_MEAN = 2'd0,
    REG_TARGET_DEV  = 2'd1,
    REG_TOLERANCE   = 2'd2
  } cfg_reg_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_NM,
    S_MUL_MM,
    S_MUL_XX,
    S_MUL_LO,
    S_MUL_HI,
    S_WSUM,
    S_DIV_WAIT,
    S_NEW_MEAN,
    S_MUL_NEWM,
    S_VAR,
    S_SQRT,
    S_SQRT_WAIT,
    S_CONV,
    S_FINISH
  } ctrl_state_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_NM,
    OP_MUL_MM,
    OP_MUL_XX,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_WSUM,
    OP_NEW_MEAN,
    OP_MUL_NEWM,
    OP_VAR,
    OP_SQRT,
    OP_CONV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic converged;
  } status_t;

endpackage

// ----- rtl/core/rmdc_if.sv -----
// rmdc channel interfaces: sample input, result output and register writes.
// Depends on rmdc_pkg for field widths.
interface rmdc_in_if;
  import rmdc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface rmdc_out_if;
  import rmdc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] running_mean;
  logic [DEV_W-1:0]         running_deviation;
  logic                     converged;
  logic [SEEN_W-1:0]        samples_seen;
  modport source(output valid, output running_mean, output running_deviation,
                 output converged, output samples_seen, input ready);
  modport sink(input valid, input running_mean, input running_deviation,
               input converged, input samples_seen, output ready);
endinterface

interface rmdc_cfg_if;
  import rmdc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/rmdc_div.sv -----
// rmdc_div: restoring divider, one quotient bit per cycle.
// Quotient must fit in QW bits. Depends on nothing beyond its parameters.
module rmdc_div #(
  parameter int NW = 64,
  parameter int DW = 25,
  parameter int QW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          busy
);
  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [QW-1:0]    q;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic             ge;

  // trial subtract of the next dividend bit
  assign trial = {rem, q[QW-1]};
  assign ge    = (trial >= {1'b0, den});
  assign quo   = q;

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QW);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(num >> QW);
      q   <= QW'(num);
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      q   <= {q[QW-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/rmdc_sqrt.sv -----
// rmdc_sqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on rmdc_pkg for RAD_W and ROOT_W.
module rmdc_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rmdc_pkg::RAD_W-1:0]   rad,
  output logic [rmdc_pkg::ROOT_W-1:0]  root,
  output logic                         busy
);
  import rmdc_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_sh;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W+1:0]  rem_t;
  logic [REM_W+1:0]  trial;
  logic              ge;

  // bring down two bits, try root*4+1
  assign rem_t = {rem, rad_sh[RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = (rem_t >= trial);

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // root and remainder update
  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= rad_sh << 2;
      rem    <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root   <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/rmdc_datapath.sv -----
// rmdc_datapath: statistics registers, shared multiplier, two dividers,
// square root unit, config registers and result register.
// Depends on rmdc_pkg, rmdc_div and rmdc_sqrt.
module rmdc_datapath #(
  parameter int CW = rmdc_pkg::COUNT_WIDTH_DEF,
  parameter int FB = rmdc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rmdc_pkg::cmd_t                     cmd,
  output rmdc_pkg::status_t                  status,
  input  logic signed [rmdc_pkg::DATA_W-1:0] sample,
  input  logic                               cfg_we,
  input  logic [rmdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmdc_pkg::DATA_W-1:0]        cfg_data,
  output logic signed [rmdc_pkg::DATA_W-1:0] out_mean,
  output logic [rmdc_pkg::DEV_W-1:0]         out_dev,
  output logic                               out_conv,
  output logic [rmdc_pkg::SEEN_W-1:0]        out_seen
);
  import rmdc_pkg::*;

  // second-moment width and variance dividend width
  localparam int MW = (((63 - FB) > VAR_W) ? (63 - FB) : VAR_W) + 1;
  localparam int WW = MW + CW;

  // configuration
  logic signed [DATA_W-1:0] tmean;
  logic [DEV_W-1:0]         tdev;
  logic [DEV_W-1:0]         tol;

  // statistics state
  logic [CW-1:0]            count;
  logic signed [DATA_W-1:0] mean;
  logic [VAR_W-1:0]         var_q;
  logic                     done;
  logic [DEV_W-1:0]         dev;

  // per-item working registers
  logic signed [DATA_W-1:0] x;
  logic signed [PROD_W-1:0] prod;
  logic signed [63:0]       acc;
  logic [MW-1:0]            m2;
  logic [MW-1:0]            sqx;
  logic [WW-1:0]            w;
  logic signed [DATA_W-1:0] nmean;

  // combinational helpers
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic                     mul_en;
  logic [DATA_W-1:0]        mag_x;
  logic [DATA_W-1:0]        mag_mean;
  logic [DATA_W-1:0]        mag_nmean;
  logic [63:0]              acc_mag;
  logic [63:0]              prod_sq;
  logic [CW:0]              den;
  logic [WW-1:0]            w_full;
  logic [MEAN_DIV_W-1:0]    mean_quo;
  logic [MW-1:0]            var_quo;
  logic                     mean_busy;
  logic                     var_busy;
  logic [DATA_W-1:0]        nmean_c;
  logic [63:0]              sec64;
  logic [63:0]              diff64;
  logic [VAR_W-1:0]         var_c;
  logic [RAD_W-1:0]         rad;
  logic [ROOT_W-1:0]        root;
  logic                     sqrt_busy;
  logic                     dev_big;
  logic [DEV_W-1:0]         dev_c;
  logic signed [DATA_W:0]   dm;
  logic [DATA_W:0]          dm_abs;
  logic signed [DEV_W:0]    dd;
  logic [DEV_W:0]           dd_abs;
  logic                     conv_c;

  // magnitudes
  assign mag_x     = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  assign mag_mean  = mean[DATA_W-1] ? DATA_W'(-mean) : DATA_W'(mean);
  assign mag_nmean = nmean[DATA_W-1] ? DATA_W'(-nmean) : DATA_W'(nmean);
  assign acc_mag   = acc[63] ? (~acc + 64'd1) : acc;
  assign prod_sq   = prod[63:0] >> FB;
  assign den       = (CW + 1)'(count) + (CW + 1)'(1);

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_MUL_NM: begin
        mul_a = $signed(MUL_W'(count));
        mul_b = {mean[DATA_W-1], mean};
      end
      OP_MUL_MM: begin
        mul_a = $signed({1'b0, mag_mean});
        mul_b = $signed({1'b0, mag_mean});
      end
      OP_MUL_XX: begin
        mul_a = $signed({1'b0, mag_x});
        mul_b = $signed({1'b0, mag_x});
      end
      OP_MUL_LO: begin
        mul_a = $signed({1'b0, m2[31:0]});
        mul_b = $signed(MUL_W'(count));
      end
      OP_MUL_HI: begin
        mul_a = $signed(MUL_W'(m2 >> 32));
        mul_b = $signed(MUL_W'(count));
      end
      OP_MUL_NEWM: begin
        mul_a = $signed({1'b0, mag_nmean});
        mul_b = $signed({1'b0, mag_nmean});
      end
      default: mul_en = 1'b0;
    endcase
  end

  // full variance dividend: low partial plus shifted high partial
  assign w_full = w + (WW'(prod[63:0]) << 32);

  rmdc_div #(.NW(MEAN_DIV_W), .DW(CW + 1), .QW(MEAN_DIV_W)) u_mean_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_MUL_XX),
    .num   (acc_mag),
    .den   (den),
    .quo   (mean_quo),
    .busy  (mean_busy)
  );

  rmdc_div #(.NW(WW), .DW(CW + 1), .QW(MW)) u_var_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_WSUM),
    .num   (w_full),
    .den   (den),
    .quo   (var_quo),
    .busy  (var_busy)
  );

  // new mean: sign restore and saturation to 32 bits
  always_comb begin
    if (acc[63]) begin
      nmean_c = (mean_quo > 64'(MEAN_MIN)) ? MEAN_MIN : (~mean_quo[31:0] + 32'd1);
    end else begin
      nmean_c = (mean_quo > 64'(MEAN_MAX)) ? MEAN_MAX : mean_quo[31:0];
    end
  end

  // variance: clamp below at zero and above at the register maximum
  assign sec64  = 64'(var_quo);
  assign diff64 = sec64 - prod_sq;
  assign var_c  = (sec64 > prod_sq) ?
                  ((diff64 > 64'(VAR_MAX)) ? VAR_MAX : diff64[VAR_W-1:0]) : '0;

  // root extraction of variance in fixed point
  assign rad     = RAD_W'(64'(var_q) << FB);
  assign dev_big = ((64'(var_q) >> (RAD_W - FB)) != 64'd0);

  rmdc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_SQRT),
    .rad   (rad),
    .root  (root),
    .busy  (sqrt_busy)
  );

  // convergence test, both differences strictly below tolerance
  assign dev_c  = dev_big ? DEV_MAX : DEV_W'(root);
  assign dm     = $signed({tmean[DATA_W-1], tmean}) - $signed({mean[DATA_W-1], mean});
  assign dm_abs = dm[DATA_W] ? (DATA_W + 1)'(-dm) : (DATA_W + 1)'(dm);
  assign dd     = $signed({1'b0, tdev}) - $signed({1'b0, dev_c});
  assign dd_abs = dd[DEV_W] ? (DEV_W + 1)'(-dd) : (DEV_W + 1)'(dd);
  assign conv_c = (dm_abs < (DATA_W + 1)'(tol)) && (dd_abs < (DEV_W + 1)'(tol));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tmean <= TARGET_MEAN_RST;
      tdev  <= TARGET_DEV_RST;
      tol   <= TOLERANCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_MEAN: tmean <= $signed(cfg_data);
        REG_TARGET_DEV:  tdev  <= cfg_data[DEV_W-1:0];
        REG_TOLERANCE:   tol   <= cfg_data[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  // statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mean  <= '0;
      var_q <= '0;
      done  <= 1'b0;
      dev   <= '0;
    end else begin
      if (cmd.op == OP_VAR) begin
        var_q <= var_c;
        mean  <= nmean;
        if (count != {CW{1'b1}}) begin
          count <= count + CW'(1);
        end
      end
      if (cmd.op == OP_CONV) begin
        dev  <= dev_c;
        done <= done | conv_c;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.op)
      OP_LOAD:     x     <= sample;
      OP_MUL_MM:   acc   <= prod[63:0] + {{32{x[DATA_W-1]}}, x};
      OP_MUL_XX:   m2    <= MW'(var_q) + MW'(prod_sq);
      OP_MUL_LO:   sqx   <= MW'(prod_sq);
      OP_MUL_HI:   w     <= WW'(prod[63:0]) + WW'(sqx);
      OP_NEW_MEAN: nmean <= $signed(nmean_c);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mean <= mean;
      out_dev  <= dev;
      out_conv <= done;
      out_seen <= SEEN_W'(count);
    end
  end

  assign status.div_busy  = mean_busy | var_busy;
  assign status.sqrt_busy = sqrt_busy;
  assign status.converged = done;

endmodule

// ----- rtl/core/rmdc_ctrl.sv -----
// rmdc_ctrl: sequencer that steps the datapath through one sample update
// and owns the input ready and result valid. Depends on rmdc_pkg.
module rmdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rmdc_pkg::cmd_t     cmd,
  input  rmdc_pkg::status_t  status
);
  import rmdc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.converged ? S_FINISH : S_MUL_NM;
        end
      end
      S_MUL_NM:   state_next = S_MUL_MM;
      S_MUL_MM:   state_next = S_MUL_XX;
      S_MUL_XX:   state_next = S_MUL_LO;
      S_MUL_LO:   state_next = S_MUL_HI;
      S_MUL_HI:   state_next = S_WSUM;
      S_WSUM:     state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_NEW_MEAN;
        end
      end
      S_NEW_MEAN: state_next = S_MUL_NEWM;
      S_MUL_NEWM: state_next = S_VAR;
      S_VAR:      state_next = S_SQRT;
      S_SQRT:     state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (!status.sqrt_busy) begin
          state_next = S_CONV;
        end
      end
      S_CONV:     state_next = S_FINISH;
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      S_MUL_NM:   cmd.op = OP_MUL_NM;
      S_MUL_MM:   cmd.op = OP_MUL_MM;
      S_MUL_XX:   cmd.op = OP_MUL_XX;
      S_MUL_LO:   cmd.op = OP_MUL_LO;
      S_MUL_HI:   cmd.op = OP_MUL_HI;
      S_WSUM:     cmd.op = OP_WSUM;
      S_NEW_MEAN: cmd.op = OP_NEW_MEAN;
      S_MUL_NEWM: cmd.op = OP_MUL_NEWM;
      S_VAR:      cmd.op = OP_VAR;
      S_SQRT:     cmd.op = OP_SQRT;
      S_CONV:     cmd.op = OP_CONV;
      S_FINISH:   cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/running_mean_deviation_convergence.sv -----
// Each sample update runs through the 64-step mean divider (the variance
// divider runs alongside) and the 31-step square root unit. One sample in
// flight: the input is not ready again until its result is loaded. Once
// converged, a sample skips the update and goes straight to the result load.
// The result register lets the next sample in while a result waits.
// Synchronous active-high reset clears count, mean, variance and the flag.
module running_mean_deviation_convergence #(
  parameter int COUNT_WIDTH = rmdc_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = rmdc_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  rmdc_in_if.sink     samples,
  rmdc_out_if.source  results,
  rmdc_cfg_if.sink    cfg
);
  import rmdc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  // register writes are always taken
  assign cfg.ready     = 1'b1;
  assign samples.ready = in_ready;
  assign results.valid = out_valid;

  rmdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  rmdc_datapath #(.CW(COUNT_WIDTH), .FB(FRAC_BITS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (samples.sample),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_mean  (results.running_mean),
    .out_dev   (results.running_deviation),
    .out_conv  (results.converged),
    .out_seen  (results.samples_seen)
  );

endmodule

// ----- rtl/core/rmdc_checker.sv -----
// rmdc_checker: port-level assertions on the running mean block, with the
// bind that attaches it to the top level. Depends on rmdc_pkg.
module rmdc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [rmdc_pkg::DATA_W-1:0] out_mean,
  input logic                               out_conv,
  input logic [rmdc_pkg::SEEN_W-1:0]        out_seen
);
  import rmdc_pkg::*;

  logic              in_xfer;
  logic              out_xfer;
  logic              conv_seen;
  logic [SEEN_W-1:0] last_seen;
  logic [2:0]        pending;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // track convergence, last count and samples awaiting a result
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_seen <= 1'b0;
      last_seen <= '0;
      pending   <= '0;
    end else begin
      if (out_xfer) begin
        conv_seen <= conv_seen | out_conv;
        last_seen <= out_seen;
      end
      if (in_xfer && !out_xfer) begin
        pending <= pending + 3'd1;
      end else if (!in_xfer && out_xfer) begin
        pending <= pending - 3'd1;
      end
    end
  end

  // converged stays set on every later result
  a_conv_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && conv_seen |-> out_conv)
    else $error("converged flag dropped");

  // count frozen once converged
  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    out_valid && conv_seen |-> out_seen == last_seen)
    else $error("sample count moved after convergence");

  // no result without a sample behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without pending sample");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_seen))
    else $error("stalled result changed");

endmodule

bind running_mean_deviation_convergence rmdc_checker u_rmdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_mean  (results.running_mean),
  .out_conv  (results.converged),
  .out_seen  (results.samples_seen)
);
